// ----- hw/rtl/smset_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted multiset package
// Shared widths, codes and the command and flag types of the cell row.
// ----------------------------------------------------------------------------
package smset_pkg;

    localparam int FUNC_W           = 2;
    localparam int VALUE_W          = 64;
    localparam int POS_W            = 6;
    localparam int COUNT_W          = 7;
    localparam int STATUS_W         = 2;
    localparam int IN_DATA_W        = 72;
    localparam int OUT_DATA_W       = 80;
    localparam int DEFAULT_CAPACITY = 64;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_ABSENT = 2'd2,
        STATUS_RANGE  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic rem;
    } t_cell_cmd;

    typedef struct packed {
        logic gt;
        logic lt;
        logic eq;
    } t_cell_flags;

endpackage

// ----- hw/rtl/smset_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted multiset cell
// Holds one entry, compares it with the broadcast value and shifts with its
// neighbors on insert and remove.
// ----------------------------------------------------------------------------
module smset_cell (
    input  logic                                   i_clk,
    input  smset_pkg::t_cell_cmd                   i_cmd,
    input  logic [smset_pkg::VALUE_W-1:0]          i_value,
    input  logic                                   i_occ,
    input  logic                                   i_hit,
    input  logic [smset_pkg::VALUE_W-1:0]          i_left_entry,
    input  smset_pkg::t_cell_flags                 i_left_flags,
    input  logic [smset_pkg::VALUE_W-1:0]          i_right_entry,
    output logic [smset_pkg::VALUE_W-1:0]          o_entry,
    output smset_pkg::t_cell_flags                 o_flags,
    output logic [smset_pkg::VALUE_W-1:0]          o_rd
);
    import smset_pkg::*;

    logic [VALUE_W-1:0] r_entry;
    logic [VALUE_W-1:0] r_rd;
    t_cell_flags        r_flags;
    t_cell_flags        n_flags;

    always_comb begin
        n_flags.gt = !i_occ || ($signed(r_entry) > $signed(i_value));
        n_flags.lt = i_occ && ($signed(r_entry) < $signed(i_value));
        n_flags.eq = i_occ && (r_entry == i_value);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_flags <= n_flags;
            r_rd    <= i_hit ? r_entry : '0;
        end
        if (i_cmd.ins) begin
            if (i_left_flags.gt) begin
                r_entry <= i_left_entry;
            end else if (r_flags.gt) begin
                r_entry <= i_value;
            end
        end else if (i_cmd.rem) begin
            if (i_occ && !r_flags.lt) begin
                r_entry <= i_right_entry;
            end
        end
    end

    assign o_entry = r_entry;
    assign o_flags = r_flags;
    assign o_rd    = r_rd;

endmodule

// ----- hw/rtl/smset_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sorted multiset controller
// Sequences compare and update phases, keeps the entry count and holds the
// result beat until it is taken.
// ----------------------------------------------------------------------------
module smset_ctrl #(
    parameter int CAPACITY = smset_pkg::DEFAULT_CAPACITY
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [smset_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [smset_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    input  logic                                   i_found,
    input  logic [smset_pkg::VALUE_W-1:0]          i_rd_word,
    output smset_pkg::t_cell_cmd                   o_cmd,
    output logic [smset_pkg::VALUE_W-1:0]          o_value,
    output logic [smset_pkg::POS_W-1:0]            o_pos,
    output logic [$clog2(CAPACITY+1)-1:0]          o_count
);
    import smset_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    t_state              r_state;
    t_state              n_state;
    t_func               r_func;
    logic [VALUE_W-1:0]  r_value;
    logic [POS_W-1:0]    r_pos;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_rd;
    logic [VALUE_W-1:0]  n_out_rd;
    t_status             r_out_status;
    t_status             n_out_status;
    logic [COUNT_W-1:0]  r_out_count;
    logic                w_accept;
    logic                w_taken;

    assign w_taken       = r_out_valid && m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_out_rd     = '0;
        n_out_status = STATUS_OK;
        o_cmd        = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = ST_UPD;
            end
            ST_UPD: begin
                n_state = ST_IDLE;
                unique case (r_func)
                    FUNC_INSERT: begin
                        if (r_count >= CW'(CAPACITY)) begin
                            n_out_status = STATUS_FULL;
                        end else begin
                            o_cmd.ins = 1'b1;
                            n_count   = r_count + 1'b1;
                        end
                    end
                    FUNC_REMOVE: begin
                        if (i_found) begin
                            o_cmd.rem = 1'b1;
                            n_count   = r_count - 1'b1;
                        end else begin
                            n_out_status = STATUS_ABSENT;
                        end
                    end
                    FUNC_READ: begin
                        if (XW'(r_pos) < XW'(r_count)) begin
                            n_out_rd = i_rd_word;
                        end else begin
                            n_out_status = STATUS_RANGE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == ST_UPD) begin
                r_out_valid <= 1'b1;
            end else if (w_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func  <= t_func'(s_axis_tdata[FUNC_W-1:0]);
            r_value <= s_axis_tdata[FUNC_W +: VALUE_W];
            r_pos   <= s_axis_tdata[FUNC_W+VALUE_W +: POS_W];
        end
        if (r_state == ST_UPD) begin
            r_out_rd     <= n_out_rd;
            r_out_status <= n_out_status;
            r_out_count  <= COUNT_W'(n_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-VALUE_W-COUNT_W-STATUS_W){1'b0}},
                            r_out_status, r_out_count, r_out_rd};
    assign o_value       = r_value;
    assign o_pos         = r_pos;
    assign o_count       = r_count;

endmodule

// ----- hw/rtl/sorted_integer_multiset_core.sv -----
// ----------------------------------------------------------------------------
// Sorted integer multiset core
// Flow: an input beat is taken while idle, the cell row then runs its compare
// and update phases, and the result beat is registered at the end of the update
// phase. A new beat is taken only while idle with no result beat left untaken.
// Reset: the entry count and all handshake state clear; entries stay unknown
// until written and are never read before that.
// ----------------------------------------------------------------------------
module sorted_integer_multiset_core #(
    parameter int CAPACITY = smset_pkg::DEFAULT_CAPACITY
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // func [1:0], value [65:2], position [71:66]
    input  logic [smset_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // read_value [63:0], count [70:64], status [72:71], zero [79:73]
    output logic [smset_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);
    import smset_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    t_cell_cmd           w_cmd;
    logic [VALUE_W-1:0]  w_value;
    logic [POS_W-1:0]    w_pos;
    logic [CW-1:0]       w_count;
    logic [VALUE_W-1:0]  w_entry [CAPACITY];
    t_cell_flags         w_flags [CAPACITY];
    logic [VALUE_W-1:0]  w_rd    [CAPACITY];
    logic [CAPACITY-1:0] w_eq;
    logic                w_found;
    logic [VALUE_W-1:0]  w_rd_word;

    smset_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_found       (w_found),
        .i_rd_word     (w_rd_word),
        .o_cmd         (w_cmd),
        .o_value       (w_value),
        .o_pos         (w_pos),
        .o_count       (w_count)
    );

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VALUE_W-1:0] w_left_entry;
        t_cell_flags        w_left_flags;
        logic [VALUE_W-1:0] w_right_entry;

        if (i == 0) begin : g_first
            assign w_left_entry = '0;
            assign w_left_flags = '0;
        end else begin : g_mid_left
            assign w_left_entry = w_entry[i-1];
            assign w_left_flags = w_flags[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign w_right_entry = '0;
        end else begin : g_mid_right
            assign w_right_entry = w_entry[i+1];
        end

        smset_cell u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cmd),
            .i_value       (w_value),
            .i_occ         (CW'(i) < w_count),
            .i_hit         (XW'(w_pos) == XW'(i)),
            .i_left_entry  (w_left_entry),
            .i_left_flags  (w_left_flags),
            .i_right_entry (w_right_entry),
            .o_entry       (w_entry[i]),
            .o_flags       (w_flags[i]),
            .o_rd          (w_rd[i])
        );

        assign w_eq[i] = w_flags[i].eq;
    end

    assign w_found = |w_eq;

    always_comb begin
        w_rd_word = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd_word = w_rd_word | w_rd[k];
        end
    end

endmodule

// ----- hw/rtl/smset_checker.sv -----
// ----------------------------------------------------------------------------
// Sorted multiset port checker
// Watches the stream ports of the core and flags illegal behavior.
// ----------------------------------------------------------------------------
module smset_checker #(
    parameter int CAPACITY = smset_pkg::DEFAULT_CAPACITY
) (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   s_axis_tvalid,
    input logic                                   s_axis_tready,
    input logic [smset_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    input logic                                   m_axis_tvalid,
    input logic                                   m_axis_tready,
    input logic [smset_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);
    import smset_pkg::*;

    logic [STATUS_W-1:0] w_status;
    logic [COUNT_W-1:0]  w_count;
    logic [VALUE_W-1:0]  w_rd;

    assign w_rd     = m_axis_tdata[VALUE_W-1:0];
    assign w_count  = m_axis_tdata[VALUE_W +: COUNT_W];
    assign w_status = m_axis_tdata[VALUE_W+COUNT_W +: STATUS_W];

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Result beat valid right after reset.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled result beat changed.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Input beat taken while the previous one is in progress.");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_status == STATUS_FULL) |-> w_count == COUNT_W'(CAPACITY))
        else $error("Full status reported below capacity.");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_status == STATUS_RANGE) |-> w_rd == '0)
        else $error("Out of range read returned nonzero data.");

endmodule

bind sorted_integer_multiset_core smset_checker #(.CAPACITY(CAPACITY)) u_smset_checker (.*);

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Sorted integer multiset core testbench
// Sends insert, remove, read and idle operations over the input stream. A
// local copy of the sorted store predicts every result beat, and each beat is
// checked field by field. Directed tests cover the empty store, the extreme
// values, duplicates and the full store. Random traffic then switches among
// filling, draining and balanced phases, with bursty input and a stalling
// output side.
// ----------------------------------------------------------------------------
module tb_top;
    import smset_pkg::*;

    localparam int          CAPACITY  = DEFAULT_CAPACITY;
    localparam int          PERIOD    = 8;
    localparam logic [63:0] VAL_MIN   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] VAL_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VAL_ZERO  = 64'h0;
    localparam logic [63:0] VAL_MINUS = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0] count;
        t_status            status;
    } t_result;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // func [1:0], value [65:2], position [71:66]
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // read_value [63:0], count [70:64], status [72:71], zero [79:73]
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic [VALUE_W-1:0] store_vals [CAPACITY];
    int                 store_count = 0;
    t_result            pending_results [$];

    int error_count = 0;
    int n_insert = 0, n_remove = 0, n_read = 0, n_nop = 0;
    int n_full = 0, n_absent = 0, n_range = 0, peak_count = 0;
    int tx_burst_left = 0;
    int rx_mode = 0;
    int rx_phase_left = 0;

    sorted_integer_multiset_core #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #(PERIOD / 2) i_clk = ~i_clk;

    function automatic t_result multiset_apply(t_func f, logic [VALUE_W-1:0] v,
                                               logic [POS_W-1:0] p);
        t_result r;
        int      at;
        r.read_value = '0;
        r.status     = STATUS_OK;
        case (f)
            FUNC_INSERT: begin
                n_insert++;
                if (store_count >= CAPACITY) begin
                    r.status = STATUS_FULL;
                end else begin
                    at = 0;
                    while (at < store_count && !($signed(v) < $signed(store_vals[at])))
                        at++;
                    for (int i = store_count; i > at; i--)
                        store_vals[i] = store_vals[i-1];
                    store_vals[at] = v;
                    store_count++;
                end
            end
            FUNC_REMOVE: begin
                n_remove++;
                at = 0;
                while (at < store_count && store_vals[at] !== v)
                    at++;
                if (at >= store_count) begin
                    r.status = STATUS_ABSENT;
                end else begin
                    for (int i = at; i + 1 < store_count; i++)
                        store_vals[i] = store_vals[i+1];
                    store_count--;
                end
            end
            FUNC_READ: begin
                n_read++;
                if (int'(p) >= store_count)
                    r.status = STATUS_RANGE;
                else
                    r.read_value = store_vals[p];
            end
            default: begin
                n_nop++;
            end
        endcase
        case (r.status)
            STATUS_FULL:   n_full++;
            STATUS_ABSENT: n_absent++;
            STATUS_RANGE:  n_range++;
            default: begin
            end
        endcase
        if (store_count > peak_count)
            peak_count = store_count;
        r.count = store_count[COUNT_W-1:0];
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = 64'(longint'($urandom_range(0, 16)) - 64'sd8);
            5: begin
                case ($urandom_range(0, 5))
                    0:       v = VAL_MIN;
                    1:       v = VAL_MAX;
                    2:       v = VAL_ZERO;
                    3:       v = VAL_MINUS;
                    4:       v = VAL_MIN + 64'd1;
                    default: v = VAL_MAX - 64'd1;
                endcase
            end
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    task automatic send_op(t_func f, logic [VALUE_W-1:0] v, logic [POS_W-1:0] p);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p, v, f};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(multiset_apply(f, v, p));
        if (tx_burst_left > 0) begin
            tx_burst_left--;
        end else begin
            gap           = $urandom_range(1, 6);
            tx_burst_left = $urandom_range(0, 12);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_empty_store();
        send_op(FUNC_READ, VAL_MINUS, 6'd0);
        send_op(FUNC_READ, VAL_ZERO, 6'd63);
        send_op(FUNC_REMOVE, VAL_ZERO, 6'd0);
        send_op(FUNC_NOP, VAL_MINUS, 6'd63);
        send_op(FUNC_INSERT, VAL_ZERO, 6'd0);
        send_op(FUNC_REMOVE, VAL_ZERO, 6'd63);
    endtask

    task automatic test_extremes();
        send_op(FUNC_INSERT, VAL_MAX, 6'd0);
        send_op(FUNC_INSERT, VAL_MIN, 6'd0);
        send_op(FUNC_INSERT, VAL_ZERO, 6'd0);
        send_op(FUNC_INSERT, VAL_MINUS, 6'd0);
        send_op(FUNC_INSERT, 64'd1, 6'd0);
        send_op(FUNC_INSERT, VAL_ZERO, 6'd0);
        send_op(FUNC_INSERT, VAL_MIN, 6'd0);
        for (int i = 0; i < 8; i++)
            send_op(FUNC_READ, VAL_ZERO, POS_W'(i));
        send_op(FUNC_REMOVE, VAL_ZERO, 6'd0);
        send_op(FUNC_REMOVE, 64'd5, 6'd0);
        send_op(FUNC_REMOVE, VAL_MAX, 6'd0);
        send_op(FUNC_REMOVE, VAL_MIN, 6'd0);
        send_op(FUNC_NOP, VAL_ZERO, 6'd0);
        send_op(FUNC_READ, VAL_ZERO, 6'd0);
        wait_drained();
    endtask

    task automatic test_full_store();
        while (store_count < CAPACITY)
            send_op(FUNC_INSERT, pick_value(), POS_W'($urandom));
        send_op(FUNC_INSERT, VAL_MAX, 6'd0);
        send_op(FUNC_INSERT, VAL_MIN, 6'd63);
        send_op(FUNC_READ, VAL_ZERO, 6'd63);
        send_op(FUNC_READ, VAL_ZERO, 6'd0);
        send_op(FUNC_REMOVE, store_vals[CAPACITY-1], 6'd0);
        send_op(FUNC_INSERT, VAL_MAX, 6'd0);
        send_op(FUNC_READ, VAL_ZERO, 6'd63);
        wait_drained();
    endtask

    task automatic test_random(int n_items);
        int                 bias;
        int                 roll;
        int                 ins_pct;
        int                 rem_pct;
        t_func              f;
        logic [VALUE_W-1:0] v;
        logic [POS_W-1:0]   p;
        bias = 0;
        for (int k = 0; k < n_items; k++) begin
            if (k % 100 == 0)
                bias = $urandom_range(0, 2);
            if (k == n_items / 2)
                wait_drained();
            ins_pct = (bias == 0) ? 70 : (bias == 1) ? 20 : 40;
            rem_pct = (bias == 0) ? 15 : (bias == 1) ? 60 : 35;
            roll    = $urandom_range(0, 99);
            v       = pick_value();
            p       = POS_W'($urandom);
            if (roll < ins_pct) begin
                f = FUNC_INSERT;
            end else if (roll < ins_pct + rem_pct) begin
                f = FUNC_REMOVE;
                if (store_count > 0 && $urandom_range(0, 99) < 85)
                    v = store_vals[$urandom_range(0, store_count - 1)];
            end else if (roll < 95) begin
                f = FUNC_READ;
                if (store_count > 0 && $urandom_range(0, 99) < 80)
                    p = POS_W'($urandom_range(0, store_count - 1));
            end else begin
                f = FUNC_NOP;
            end
            send_op(f, v, p);
        end
    endtask

    always @(negedge i_clk) begin
        if (rx_phase_left == 0) begin
            rx_mode       = $urandom_range(0, 3);
            rx_phase_left = $urandom_range(20, 120);
        end else begin
            rx_phase_left--;
        end
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= rx_phase_left[2];
        endcase
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("Unexpected result beat: %h", m_axis_tdata);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_axis_tdata[63:0] !== exp_r.read_value) begin
                    $error("read_value mismatch: expected %0d, actual %0d",
                           $signed(exp_r.read_value), $signed(m_axis_tdata[63:0]));
                    error_count++;
                end
                if (m_axis_tdata[70:64] !== exp_r.count) begin
                    $error("count mismatch: expected %0d, actual %0d",
                           exp_r.count, m_axis_tdata[70:64]);
                    error_count++;
                end
                if (m_axis_tdata[72:71] !== exp_r.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           exp_r.status, m_axis_tdata[72:71]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_store();
        test_extremes();
        test_full_store();
        test_random(600);
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            error_count++;
        end
        $display("Sent %0d inserts, %0d removes, %0d reads and %0d idle operations.",
                 n_insert, n_remove, n_read, n_nop);
        $display("Saw %0d full inserts, %0d absent removes, %0d reads out of range; peak %0d.",
                 n_full, n_absent, n_range, peak_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding.", pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
